[src/int_divide_remainder_unit_assert.svh]
// assertion macros for the integer divide and remainder unit
// used by the top level, idru_pre and idru_step; plain text, no dependencies
`ifndef INT_DIVIDE_REMAINDER_UNIT_ASSERT_SVH
`define INT_DIVIDE_REMAINDER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define IDRU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");
`define IDRU_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next cycle check failed");
`else
`define IDRU_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define IDRU_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[src/idru_pkg.sv]
// shared types, constants and helpers for the integer divide and remainder unit
// no dependencies
`default_nettype none
package idru_pkg;
	localparam int DATA_W    = 32;
	localparam int FUNC_W    = 2;
	localparam int STEP_BITS = 2;
	localparam int N_STEPS   = DATA_W / STEP_BITS;

	typedef enum logic [FUNC_W-1:0] {
		FN_DIVU = 2'd0,
		FN_REMU = 2'd1,
		FN_DIV  = 2'd2,
		FN_REM  = 2'd3
	} func_t;

	// partial remainder, dividend bits shifting out and quotient bits shifting in
	typedef struct packed {
		logic [DATA_W-1:0] rem;
		logic [DATA_W-1:0] aq;
		logic [DATA_W-1:0] dvs;
		logic              is_rem;
		logic              neg;
	} div_word_t;

	function automatic logic [DATA_W-1:0] cond_neg(input logic [DATA_W-1:0] v, input logic n);
		return n ? (~v + {{(DATA_W-1){1'b0}}, 1'b1}) : v;
	endfunction
endpackage
`default_nettype wire

[src/int_divide_remainder_unit.sv]
// top level of the 32-bit integer divide and remainder unit
// depends on idru_pkg, idru_pre, idru_step, idru_post and the assertion macro header
//
// Input channel: in_valid/in_ready with func (0 divu, 1 remu, 2 div, 3 rem),
// dividend and divisor. Output channel: out_valid/out_ready with result.
// The decode stage takes the word at the accepting edge, then sixteen divider
// stages of two quotient bits each and one output stage follow, each of them
// registered, before the word reaches out_valid.
// Throughput is one word per cycle unless stalled; every stage register has
// its own valid bit, so bubbles close up and the input is taken while results
// wait. When the receiver holds out_ready low the pipeline fills stage by stage
// and in_ready drops only once every stage holds a word; nothing is lost
// or repeated. Division by zero gives all ones for a quotient and the
// dividend for a remainder; the most negative value over minus one gives
// itself as quotient and zero as remainder.
// Reset (arst_n low) clears all valid bits at once; words in flight are
// dropped and in_ready is high as soon as the valid bits are clear.
`default_nettype none
`include "int_divide_remainder_unit_assert.svh"
module int_divide_remainder_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [idru_pkg::FUNC_W-1:0]   func,
	input  wire logic [idru_pkg::DATA_W-1:0]   dividend,
	input  wire logic [idru_pkg::DATA_W-1:0]   divisor,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [idru_pkg::DATA_W-1:0]        result
);
	import idru_pkg::*;

	div_word_t word_a  [N_STEPS+1];
	logic      valid_a [N_STEPS+1];
	logic      ready_a [N_STEPS+1];

	idru_pre u_pre (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.dividend  (dividend),
		.divisor   (divisor),
		.out_valid (valid_a[0]),
		.out_ready (ready_a[0]),
		.out_word  (word_a[0])
	);

	for (genvar g = 0; g < N_STEPS; g++) begin : g_step
		idru_step u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (valid_a[g]),
			.in_ready  (ready_a[g]),
			.in_word   (word_a[g]),
			.out_valid (valid_a[g+1]),
			.out_ready (ready_a[g+1]),
			.out_word  (word_a[g+1])
		);
	end

	idru_post u_post (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_a[N_STEPS]),
		.in_ready  (ready_a[N_STEPS]),
		.in_word   (word_a[N_STEPS]),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.result    (result)
	);

	// back pressure only comes from a full pipeline behind a stalled output
	`IDRU_ASSERT_IMP(a_stall_only_when_full, clk, arst_n, !in_ready,
		out_valid && !out_ready && valid_a[0] && valid_a[N_STEPS])
	`IDRU_ASSERT_NXT(a_word_reaches_output, clk, arst_n,
		valid_a[N_STEPS] && ready_a[N_STEPS], out_valid)
endmodule
`default_nettype wire

[src/idru_pre.sv]
// first stage: decodes the function, takes operand magnitudes and the result sign
// depends on idru_pkg and the assertion macro header
`default_nettype none
`include "int_divide_remainder_unit_assert.svh"
module idru_pre (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [idru_pkg::FUNC_W-1:0]   func,
	input  wire logic [idru_pkg::DATA_W-1:0]   dividend,
	input  wire logic [idru_pkg::DATA_W-1:0]   divisor,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output idru_pkg::div_word_t                out_word
);
	import idru_pkg::*;

	func_t     fn;
	logic      signed_op;
	logic      neg_a;
	logic      neg_b;
	div_word_t nxt;
	logic      valid_s1;
	div_word_t word_s1;

	always_comb begin
		fn         = func_t'(func);
		signed_op  = (fn == FN_DIV) || (fn == FN_REM);
		neg_a      = signed_op & dividend[DATA_W-1];
		neg_b      = signed_op & divisor[DATA_W-1];
		nxt.rem    = '0;
		nxt.aq     = cond_neg(dividend, neg_a);
		nxt.dvs    = cond_neg(divisor, neg_b);
		nxt.is_rem = (fn == FN_REMU) || (fn == FN_REM);
		// a zero divisor leaves the all-ones quotient unsigned
		nxt.neg    = nxt.is_rem ? neg_a : ((neg_a ^ neg_b) & (divisor != '0));
	end

	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;
	assign out_word  = word_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			word_s1 <= nxt;
		end
	end

	`IDRU_ASSERT_IMP(a_zero_div_unsigned, clk, arst_n,
		valid_s1 && (word_s1.dvs == '0) && !word_s1.is_rem, !word_s1.neg)
	`IDRU_ASSERT_IMP(a_rem_starts_clear, clk, arst_n, valid_s1, word_s1.rem == '0)
endmodule
`default_nettype wire

[src/idru_step.sv]
// one divider stage: retires two quotient bits by restoring subtraction
// depends on idru_pkg and the assertion macro header
`default_nettype none
`include "int_divide_remainder_unit_assert.svh"
module idru_step (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire idru_pkg::div_word_t  in_word,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output idru_pkg::div_word_t       out_word
);
	import idru_pkg::*;

	logic [DATA_W:0] trial;
	logic [DATA_W:0] diff;
	div_word_t       nxt;
	logic            valid_q;
	div_word_t       word_q;

	always_comb begin
		nxt   = in_word;
		trial = '0;
		diff  = '0;
		for (int i = 0; i < STEP_BITS; i++) begin
			trial   = {nxt.rem, nxt.aq[DATA_W-1]};
			diff    = trial - {1'b0, nxt.dvs};
			nxt.aq  = {nxt.aq[DATA_W-2:0], ~diff[DATA_W]};
			nxt.rem = diff[DATA_W] ? trial[DATA_W-1:0] : diff[DATA_W-1:0];
		end
	end

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_word  = word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			word_q <= nxt;
		end
	end

	`IDRU_ASSERT_IMP(a_rem_below_divisor, clk, arst_n,
		valid_q && (word_q.dvs != '0), word_q.rem < word_q.dvs)
endmodule
`default_nettype wire

[src/idru_post.sv]
// last stage: picks quotient or remainder, applies the sign, holds the output word
// depends on idru_pkg
`default_nettype none
module idru_post (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire idru_pkg::div_word_t         in_word,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [idru_pkg::DATA_W-1:0]      result
);
	import idru_pkg::*;

	logic [DATA_W-1:0] value;
	logic              valid_q;
	logic [DATA_W-1:0] result_q;

	assign value     = in_word.is_rem ? in_word.rem : in_word.aq;
	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign result    = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			result_q <= cond_neg(value, in_word.neg);
		end
	end
endmodule
`default_nettype wire
